[rtl/core/fcbe_pkg.sv]
// fcbe_pkg: shared constants and types of the face crop box expand/clamp block
// no dependencies
`timescale 1ns / 1ps

package fcbe_pkg;

    // integer bits of the unsigned scale format
    localparam int SCALE_INT_BITS = 4;

    // fixed result field widths
    localparam int OUT_POS_W  = 18;
    localparam int OUT_SIZE_W = 17;

    // configuration register map
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODEL_SCALE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_FRAC_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_FRAC_Y = 3'd4;

    // register reset values
    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam int RST_MODEL_SCALE  = 11059;

    // per-box status carried down the pipeline
    typedef struct packed {
        logic inval;
        logic sat_x;
        logic sat_y;
    } t_flags;

endpackage

[rtl/core/fcbe_if.sv]
// fcbe_box_if / fcbe_crop_if: valid/ready channels for box requests and crop results
// depends on fcbe_pkg
`timescale 1ns / 1ps

interface fcbe_box_if #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 12
);
    logic                                          valid;
    logic                                          ready;
    logic [COORD_BITS-1:0]                         box_left;
    logic [COORD_BITS-1:0]                         box_top;
    logic [COORD_BITS-1:0]                         box_right;
    logic [COORD_BITS-1:0]                         box_bottom;
    logic [FRAC_BITS+fcbe_pkg::SCALE_INT_BITS-1:0] min_scale;

    modport source (output valid, box_left, box_top, box_right, box_bottom, min_scale,
                    input ready);
    modport sink (input valid, box_left, box_top, box_right, box_bottom, min_scale,
                  output ready);
endinterface

interface fcbe_crop_if;
    import fcbe_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [OUT_POS_W-1:0]  crop_left;
    logic signed [OUT_POS_W-1:0]  crop_top;
    logic        [OUT_SIZE_W-1:0] crop_width;
    logic        [OUT_SIZE_W-1:0] crop_height;
    logic                         box_invalid;

    modport source (output valid, crop_left, crop_top, crop_width, crop_height, box_invalid,
                    input ready);
    modport sink (input valid, crop_left, crop_top, crop_width, crop_height, box_invalid,
                  output ready);
endinterface

[rtl/core/fcbe_front.sv]
// fcbe_front: box size, validity, center, shift products and divider setup
// depends on fcbe_pkg
`timescale 1ns / 1ps

module fcbe_front #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 12
) (
    input  logic        [COORD_BITS-1:0]               i_left,
    input  logic        [COORD_BITS-1:0]               i_top,
    input  logic        [COORD_BITS-1:0]               i_right,
    input  logic        [COORD_BITS-1:0]               i_bottom,
    input  logic        [COORD_BITS:0]                 i_wm1,
    input  logic        [COORD_BITS:0]                 i_hm1,
    input  logic signed [FRAC_BITS:0]                  i_sfx,
    input  logic signed [FRAC_BITS:0]                  i_sfy,
    output logic        [COORD_BITS:0]                 o_bw,
    output logic        [COORD_BITS:0]                 o_bh,
    output logic        [COORD_BITS:0]                 o_cx,
    output logic        [COORD_BITS:0]                 o_cy,
    output logic signed [COORD_BITS+FRAC_BITS+2:0]     o_px,
    output logic signed [COORD_BITS+FRAC_BITS+2:0]     o_py,
    output logic        [COORD_BITS:0]                 o_rem_x,
    output logic        [COORD_BITS:0]                 o_rem_y,
    output fcbe_pkg::t_flags                           o_flags
);
    import fcbe_pkg::*;

    localparam int DW = COORD_BITS + 1;

    logic [DW-1:0] w_init_x;
    logic [DW-1:0] w_init_y;

    assign o_bw = DW'(i_right) - DW'(i_left) + DW'(1);
    assign o_bh = DW'(i_bottom) - DW'(i_top) + DW'(1);

    assign o_cx = (o_bw >> 1) + DW'(i_left);
    assign o_cy = (o_bh >> 1) + DW'(i_top);

    assign o_px = $signed({1'b0, o_bw}) * i_sfx;
    assign o_py = $signed({1'b0, o_bh}) * i_sfy;

    // leading dividend bits; quotient cannot fit the scale format if they reach the divisor
    assign w_init_x = i_wm1 >> SCALE_INT_BITS;
    assign w_init_y = i_hm1 >> SCALE_INT_BITS;
    assign o_rem_x  = w_init_x;
    assign o_rem_y  = w_init_y;

    assign o_flags.inval = (i_right < i_left) || (i_bottom < i_top);
    assign o_flags.sat_x = (w_init_x >= o_bw);
    assign o_flags.sat_y = (w_init_y >= o_bh);

endmodule

[rtl/core/fcbe_div_step.sv]
// fcbe_div_step: one restoring division step, one quotient bit
// no dependencies
`timescale 1ns / 1ps

module fcbe_div_step #(
    parameter int DW = 13
) (
    input  logic [DW-1:0] i_rem,
    input  logic [DW-1:0] i_div,
    input  logic          i_bit,
    output logic [DW-1:0] o_rem,
    output logic          o_qbit
);
    logic [DW:0] w_trial;

    assign w_trial = {i_rem, i_bit};
    assign o_qbit  = (w_trial >= {1'b0, i_div});
    assign o_rem   = o_qbit ? DW'(w_trial - {1'b0, i_div}) : DW'(w_trial);

endmodule

[rtl/core/fcbe_scale.sv]
// fcbe_scale: effective scale selection and truncated shift offsets
// depends on fcbe_pkg
`timescale 1ns / 1ps

module fcbe_scale #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 12
) (
    input  logic        [FRAC_BITS+fcbe_pkg::SCALE_INT_BITS-1:0] i_qx,
    input  logic        [FRAC_BITS+fcbe_pkg::SCALE_INT_BITS-1:0] i_qy,
    input  logic        [FRAC_BITS+fcbe_pkg::SCALE_INT_BITS-1:0] i_model_scale,
    input  logic        [FRAC_BITS+fcbe_pkg::SCALE_INT_BITS-1:0] i_min_scale,
    input  fcbe_pkg::t_flags                                     i_flags,
    input  logic signed [COORD_BITS+FRAC_BITS+2:0]               i_px,
    input  logic signed [COORD_BITS+FRAC_BITS+2:0]               i_py,
    output logic        [FRAC_BITS+fcbe_pkg::SCALE_INT_BITS-1:0] o_eff,
    output logic signed [COORD_BITS+5:0]                         o_sx,
    output logic signed [COORD_BITS+5:0]                         o_sy
);
    import fcbe_pkg::*;

    localparam int QW     = FRAC_BITS + SCALE_INT_BITS;
    localparam int PROD_W = COORD_BITS + FRAC_BITS + 3;
    localparam int POS_W  = COORD_BITS + 6;

    logic        [QW-1:0]     w_fit;
    logic signed [PROD_W-1:0] w_bias_x;
    logic signed [PROD_W-1:0] w_bias_y;
    logic signed [PROD_W-1:0] w_sum_x;
    logic signed [PROD_W-1:0] w_sum_y;

    always_comb begin
        w_fit = i_model_scale;
        if (!i_flags.sat_x && (i_qx < w_fit)) begin
            w_fit = i_qx;
        end
        if (!i_flags.sat_y && (i_qy < w_fit)) begin
            w_fit = i_qy;
        end
        o_eff = (i_min_scale > w_fit) ? i_min_scale : w_fit;
    end

    // round toward zero: bias negative products before the arithmetic shift
    assign w_bias_x = i_px[PROD_W-1] ? $signed({{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                                     : '0;
    assign w_bias_y = i_py[PROD_W-1] ? $signed({{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{1'b1}}})
                                     : '0;
    assign w_sum_x  = i_px + w_bias_x;
    assign w_sum_y  = i_py + w_bias_y;
    assign o_sx     = POS_W'(w_sum_x >>> FRAC_BITS);
    assign o_sy     = POS_W'(w_sum_y >>> FRAC_BITS);

endmodule

[rtl/core/fcbe_place.sv]
// fcbe_place: three-stage corner placement and frame clamp for one axis
// no dependencies
`timescale 1ns / 1ps

module fcbe_place #(
    parameter int COORD_BITS = 12
) (
    input  logic                        i_clk,
    input  logic [2:0]                  i_adv,
    input  logic [COORD_BITS:0]         i_c,
    input  logic [COORD_BITS+3:0]       i_n,
    input  logic signed [COORD_BITS+5:0] i_s,
    input  logic [COORD_BITS:0]         i_dim,
    output logic signed [COORD_BITS+5:0] o_pos
);
    localparam int POS_W = COORD_BITS + 6;
    localparam int NW_W  = COORD_BITS + 4;

    logic        [NW_W-1:0]  w_half;
    logic signed [POS_W-1:0] w_dim;
    logic signed [POS_W-1:0] r_la;
    logic signed [POS_W-1:0] r_ra;
    logic signed [POS_W-1:0] r_lb;
    logic signed [POS_W-1:0] r_rb;
    logic signed [POS_W-1:0] r_lc;

    assign w_half = i_n >> 1;
    assign w_dim  = $signed(POS_W'(i_dim));

    // centered corners plus shift
    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_la <= $signed(POS_W'(i_c)) - $signed(POS_W'(w_half)) + i_s;
            r_ra <= $signed(POS_W'(i_c)) + $signed(POS_W'(w_half)) + i_s;
        end
    end

    // push in at the low edge
    always_ff @(posedge i_clk) begin
        if (i_adv[1]) begin
            if (r_la < 0) begin
                r_lb <= '0;
                r_rb <= r_ra - r_la;
            end else begin
                r_lb <= r_la;
                r_rb <= r_ra;
            end
        end
    end

    // then at the high edge
    always_ff @(posedge i_clk) begin
        if (i_adv[2]) begin
            if (r_rb >= w_dim) begin
                r_lc <= r_lb - (r_rb - w_dim + POS_W'(1));
            end else begin
                r_lc <= r_lb;
            end
        end
    end

    assign o_pos = r_lc;

endmodule

[rtl/core/face_crop_box_expand_clamp.sv]
// face_crop_box_expand_clamp: scales a detected box about its center and clamps it to the frame
// depends on fcbe_pkg, fcbe_if, fcbe_front, fcbe_div_step, fcbe_scale, fcbe_place
//
//  channel   | dir | handshake     | payload
//  ----------+-----+---------------+---------------------------------------------------
//  i_box     | in  | valid/ready   | box_left, box_top, box_right, box_bottom, min_scale
//  o_crop    | out | valid/ready   | crop_left, crop_top, crop_width, crop_height, box_invalid
//  i_cfg_*   | in  | write enable  | register index, write data
//
// one box per cycle sustained while o_crop.ready holds; the fit-scale divider produces one
// quotient bit per stage for both axes in parallel.
// every stage has its own valid bit and only stalls when the stage after it is full, so
// bubbles collapse and requests keep entering while a result waits at the output.
// synchronous active-low reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps

module face_crop_box_expand_clamp #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    fcbe_box_if.sink                               i_box,
    fcbe_crop_if.source                            o_crop,
    input  logic                                   i_cfg_we,
    input  logic [fcbe_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [((COORD_BITS + 1 > FRAC_BITS + fcbe_pkg::SCALE_INT_BITS) ?
                   COORD_BITS + 1 : FRAC_BITS + fcbe_pkg::SCALE_INT_BITS)-1:0] i_cfg_data
);
    import fcbe_pkg::*;

    localparam int DW     = COORD_BITS + 1;
    localparam int QW     = FRAC_BITS + SCALE_INT_BITS;
    localparam int SFW    = FRAC_BITS + 1;
    localparam int PROD_W = COORD_BITS + FRAC_BITS + 3;
    localparam int POS_W  = COORD_BITS + 6;
    localparam int NW_W   = COORD_BITS + 4;
    localparam int MUL_W  = DW + QW;

    // stage map: front, QW divider steps, scale select, multiply, three placement steps
    localparam int S_SEL = QW + 1;
    localparam int S_MUL = QW + 2;
    localparam int S_PA  = QW + 3;
    localparam int NS    = QW + 6;

    // configuration registers
    logic        [DW-1:0]  r_img_w;
    logic        [DW-1:0]  r_img_h;
    logic        [QW-1:0]  r_model_scale;
    logic signed [SFW-1:0] r_sfx;
    logic signed [SFW-1:0] r_sfy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w       <= DW'(RST_IMAGE_WIDTH);
            r_img_h       <= DW'(RST_IMAGE_HEIGHT);
            r_model_scale <= QW'(RST_MODEL_SCALE);
            r_sfx         <= '0;
            r_sfy         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    r_img_w <= i_cfg_data[DW-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_img_h <= i_cfg_data[DW-1:0];
                end
                REG_MODEL_SCALE: begin
                    r_model_scale <= i_cfg_data[QW-1:0];
                end
                REG_SHIFT_FRAC_X: begin
                    r_sfx <= $signed(i_cfg_data[SFW-1:0]);
                end
                REG_SHIFT_FRAC_Y: begin
                    r_sfy <= $signed(i_cfg_data[SFW-1:0]);
                end
                default: begin
                end
            endcase
        end
    end

    // frame extent minus one, zero frame taken as zero
    logic [DW-1:0] w_wm1;
    logic [DW-1:0] w_hm1;
    logic [QW-1:0] w_num_lo_x;
    logic [QW-1:0] w_num_lo_y;

    assign w_wm1      = (r_img_w == '0) ? '0 : r_img_w - DW'(1);
    assign w_hm1      = (r_img_h == '0) ? '0 : r_img_h - DW'(1);
    assign w_num_lo_x = {w_wm1[SCALE_INT_BITS-1:0], {FRAC_BITS{1'b0}}};
    assign w_num_lo_y = {w_hm1[SCALE_INT_BITS-1:0], {FRAC_BITS{1'b0}}};

    // pipeline control
    logic [NS-1:0] r_v;
    logic [NS:0]   w_adv;

    assign w_adv[NS] = o_crop.ready;
    genvar s;
    generate
        for (s = 0; s < NS; s++) begin : g_adv
            assign w_adv[s] = ~r_v[s] | w_adv[s+1];
        end
    endgenerate

    assign i_box.ready = w_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = NS - 1; k > 0; k--) begin
                if (w_adv[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
            if (w_adv[0]) begin
                r_v[0] <= i_box.valid;
            end
        end
    end

    // front stage
    logic        [DW-1:0]     w_f_bw;
    logic        [DW-1:0]     w_f_bh;
    logic        [DW-1:0]     w_f_cx;
    logic        [DW-1:0]     w_f_cy;
    logic signed [PROD_W-1:0] w_f_px;
    logic signed [PROD_W-1:0] w_f_py;
    logic        [DW-1:0]     w_f_rem_x;
    logic        [DW-1:0]     w_f_rem_y;
    t_flags                   w_f_flags;

    fcbe_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .i_left   (i_box.box_left),
        .i_top    (i_box.box_top),
        .i_right  (i_box.box_right),
        .i_bottom (i_box.box_bottom),
        .i_wm1    (w_wm1),
        .i_hm1    (w_hm1),
        .i_sfx    (r_sfx),
        .i_sfy    (r_sfy),
        .o_bw     (w_f_bw),
        .o_bh     (w_f_bh),
        .o_cx     (w_f_cx),
        .o_cy     (w_f_cy),
        .o_px     (w_f_px),
        .o_py     (w_f_py),
        .o_rem_x  (w_f_rem_x),
        .o_rem_y  (w_f_rem_y),
        .o_flags  (w_f_flags)
    );

    // front and divider stage registers, index 0 is the front stage
    logic        [DW-1:0]     r_bw   [0:QW];
    logic        [DW-1:0]     r_bh   [0:QW];
    logic        [DW-1:0]     r_cx   [0:QW];
    logic        [DW-1:0]     r_cy   [0:QW];
    logic signed [PROD_W-1:0] r_px   [0:QW];
    logic signed [PROD_W-1:0] r_py   [0:QW];
    logic        [QW-1:0]     r_smin [0:QW];
    t_flags                   r_flg  [0:QW];
    logic        [DW-1:0]     r_rx   [0:QW];
    logic        [DW-1:0]     r_ry   [0:QW];
    logic        [QW-1:0]     r_qx   [0:QW];
    logic        [QW-1:0]     r_qy   [0:QW];

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r_bw[0]   <= w_f_bw;
            r_bh[0]   <= w_f_bh;
            r_cx[0]   <= w_f_cx;
            r_cy[0]   <= w_f_cy;
            r_px[0]   <= w_f_px;
            r_py[0]   <= w_f_py;
            r_smin[0] <= i_box.min_scale;
            r_flg[0]  <= w_f_flags;
            r_rx[0]   <= w_f_rem_x;
            r_ry[0]   <= w_f_rem_y;
            r_qx[0]   <= '0;
            r_qy[0]   <= '0;
        end
    end

    genvar k;
    generate
        for (k = 1; k <= QW; k++) begin : g_div
            logic [DW-1:0] w_rem_x;
            logic [DW-1:0] w_rem_y;
            logic          w_qb_x;
            logic          w_qb_y;

            fcbe_div_step #(.DW(DW)) u_step_x (
                .i_rem  (r_rx[k-1]),
                .i_div  (r_bw[k-1]),
                .i_bit  (w_num_lo_x[QW-k]),
                .o_rem  (w_rem_x),
                .o_qbit (w_qb_x)
            );

            fcbe_div_step #(.DW(DW)) u_step_y (
                .i_rem  (r_ry[k-1]),
                .i_div  (r_bh[k-1]),
                .i_bit  (w_num_lo_y[QW-k]),
                .o_rem  (w_rem_y),
                .o_qbit (w_qb_y)
            );

            always_ff @(posedge i_clk) begin
                if (w_adv[k]) begin
                    r_bw[k]   <= r_bw[k-1];
                    r_bh[k]   <= r_bh[k-1];
                    r_cx[k]   <= r_cx[k-1];
                    r_cy[k]   <= r_cy[k-1];
                    r_px[k]   <= r_px[k-1];
                    r_py[k]   <= r_py[k-1];
                    r_smin[k] <= r_smin[k-1];
                    r_flg[k]  <= r_flg[k-1];
                    r_rx[k]   <= w_rem_x;
                    r_ry[k]   <= w_rem_y;
                    r_qx[k]   <= {r_qx[k-1][QW-2:0], w_qb_x};
                    r_qy[k]   <= {r_qy[k-1][QW-2:0], w_qb_y};
                end
            end
        end
    endgenerate

    // scale select stage
    logic        [QW-1:0]    w_eff;
    logic signed [POS_W-1:0] w_sx;
    logic signed [POS_W-1:0] w_sy;

    fcbe_scale #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_scale (
        .i_qx          (r_qx[QW]),
        .i_qy          (r_qy[QW]),
        .i_model_scale (r_model_scale),
        .i_min_scale   (r_smin[QW]),
        .i_flags       (r_flg[QW]),
        .i_px          (r_px[QW]),
        .i_py          (r_py[QW]),
        .o_eff         (w_eff),
        .o_sx          (w_sx),
        .o_sy          (w_sy)
    );

    logic        [QW-1:0]    r_s_eff;
    logic        [QW-1:0]    r_s_smin;
    logic        [DW-1:0]    r_s_bw;
    logic        [DW-1:0]    r_s_bh;
    logic        [DW-1:0]    r_s_cx;
    logic        [DW-1:0]    r_s_cy;
    logic signed [POS_W-1:0] r_s_sx;
    logic signed [POS_W-1:0] r_s_sy;
    logic                    r_s_inv;

    always_ff @(posedge i_clk) begin
        if (w_adv[S_SEL]) begin
            r_s_eff  <= w_eff;
            r_s_smin <= r_smin[QW];
            r_s_bw   <= r_bw[QW];
            r_s_bh   <= r_bh[QW];
            r_s_cx   <= r_cx[QW];
            r_s_cy   <= r_cy[QW];
            r_s_sx   <= w_sx;
            r_s_sy   <= w_sy;
            r_s_inv  <= r_flg[QW].inval;
        end
    end

    // multiply stage: crop size = box size * scale, truncated
    logic [MUL_W-1:0] w_mul_x;
    logic [MUL_W-1:0] w_mul_y;

    assign w_mul_x = MUL_W'(r_s_bw) * MUL_W'(r_s_eff);
    assign w_mul_y = MUL_W'(r_s_bh) * MUL_W'(r_s_eff);

    logic        [NW_W-1:0]  r_m_nw;
    logic        [NW_W-1:0]  r_m_nh;
    logic        [DW-1:0]    r_m_cx;
    logic        [DW-1:0]    r_m_cy;
    logic signed [POS_W-1:0] r_m_sx;
    logic signed [POS_W-1:0] r_m_sy;
    logic                    r_m_inv;

    always_ff @(posedge i_clk) begin
        if (w_adv[S_MUL]) begin
            r_m_nw  <= w_mul_x[FRAC_BITS +: NW_W];
            r_m_nh  <= w_mul_y[FRAC_BITS +: NW_W];
            r_m_cx  <= r_s_cx;
            r_m_cy  <= r_s_cy;
            r_m_sx  <= r_s_sx;
            r_m_sy  <= r_s_sy;
            r_m_inv <= r_s_inv;
        end
    end

    // placement stages
    logic signed [POS_W-1:0] w_pos_x;
    logic signed [POS_W-1:0] w_pos_y;

    fcbe_place #(.COORD_BITS(COORD_BITS)) u_place_x (
        .i_clk (i_clk),
        .i_adv (w_adv[S_PA +: 3]),
        .i_c   (r_m_cx),
        .i_n   (r_m_nw),
        .i_s   (r_m_sx),
        .i_dim (r_img_w),
        .o_pos (w_pos_x)
    );

    fcbe_place #(.COORD_BITS(COORD_BITS)) u_place_y (
        .i_clk (i_clk),
        .i_adv (w_adv[S_PA +: 3]),
        .i_c   (r_m_cy),
        .i_n   (r_m_nh),
        .i_s   (r_m_sy),
        .i_dim (r_img_h),
        .o_pos (w_pos_y)
    );

    logic [NW_W-1:0] r_p_nw  [0:2];
    logic [NW_W-1:0] r_p_nh  [0:2];
    logic            r_p_inv [0:2];

    always_ff @(posedge i_clk) begin
        if (w_adv[S_PA]) begin
            r_p_nw[0]  <= r_m_nw;
            r_p_nh[0]  <= r_m_nh;
            r_p_inv[0] <= r_m_inv;
        end
        for (int j = 1; j < 3; j++) begin
            if (w_adv[S_PA + j]) begin
                r_p_nw[j]  <= r_p_nw[j-1];
                r_p_nh[j]  <= r_p_nh[j-1];
                r_p_inv[j] <= r_p_inv[j-1];
            end
        end
    end

    // result; an invalid box reports all-zero geometry
    assign o_crop.valid       = r_v[NS-1];
    assign o_crop.box_invalid = r_p_inv[2];
    assign o_crop.crop_left   = r_p_inv[2] ? '0 : OUT_POS_W'(w_pos_x);
    assign o_crop.crop_top    = r_p_inv[2] ? '0 : OUT_POS_W'(w_pos_y);
    assign o_crop.crop_width  = r_p_inv[2] ? '0 : OUT_SIZE_W'(r_p_nw[2]);
    assign o_crop.crop_height = r_p_inv[2] ? '0 : OUT_SIZE_W'(r_p_nh[2]);

    // checks
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_crop.valid && o_crop.box_invalid |->
            o_crop.crop_left == '0 && o_crop.crop_top == '0 &&
            o_crop.crop_width == '0 && o_crop.crop_height == '0)
        else $error("invalid box result carries nonzero geometry");

    a_stall_front_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_box.ready |-> r_v[0])
        else $error("input stalled while front stage is empty");

    a_scale_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S_SEL] |-> r_s_eff >= r_s_smin)
        else $error("effective scale below requested minimum");

endmodule
